// ----- src/assert_macros.svh -----
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by hbd_ctrl; each use sits on its own line.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, quiet while in reset
`define HBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition that must hold at every rising edge outside reset
`define HBD_ASSERT_ALWAYS(lbl, cond, msg) \
    `HBD_ASSERT(lbl, (1'b1 |-> (cond)), msg)

`endif

// ----- src/hbd_pkg.sv -----
// ------------------------------------------------------------------------
// hbd_pkg
// Types, codes and constants of the dual H-bridge drive.
// ------------------------------------------------------------------------
package hbd_pkg;

    // Widths of the fixed fields
    localparam int SPEED_W  = 16;
    localparam int MAG_W    = 15;
    localparam int PERIOD_W = 16;
    localparam int DB_W     = 14;
    localparam int LIMIT_W  = 11;
    localparam int CUR_W    = 12;
    localparam int TILT_W   = 16;
    localparam int CUTOFF_W = 14;
    localparam int PROD_W   = MAG_W + PERIOD_W;
    localparam int FRAC_W   = 14;
    localparam int NUM_CH   = 2;

    // Full-scale speed magnitude in Q1.14
    localparam logic [MAG_W-1:0] SPEED_ONE = 15'd16384;

    // Command codes
    typedef enum logic [2:0] {
        OP_INIT      = 3'd0,
        OP_SET_SPEED = 3'd1,
        OP_SET_BOTH  = 3'd2,
        OP_BRAKE     = 3'd3,
        OP_COAST     = 3'd4,
        OP_ESTOP     = 3'd5,
        OP_CHECK     = 3'd6
    } op_t;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_INIT    = 3'd1,
        ST_FAULT       = 3'd2,
        ST_INVALID     = 3'd3,
        ST_OVERCURRENT = 3'd4
    } status_t;

    // Register indexes of the write port
    localparam logic [2:0] REG_PWM_PERIOD = 3'd0;
    localparam logic [2:0] REG_DB_LEFT    = 3'd1;
    localparam logic [2:0] REG_DB_RIGHT   = 3'd2;
    localparam logic [2:0] REG_ILIM_LEFT  = 3'd3;
    localparam logic [2:0] REG_ILIM_RIGHT = 3'd4;
    localparam logic [2:0] REG_TILT_CUT   = 3'd5;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
    localparam logic [DB_W-1:0]     DB_RST     = 14'd819;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 11'd2000;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 14'd4500;

    // Configuration register set
    typedef struct packed {
        logic [PERIOD_W-1:0] pwm_period;
        logic [DB_W-1:0]     deadband_left;
        logic [DB_W-1:0]     deadband_right;
        logic [LIMIT_W-1:0]  current_limit_left;
        logic [LIMIT_W-1:0]  current_limit_right;
        logic [CUTOFF_W-1:0] tilt_cutoff;
    } cfg_t;

    // What one lane found for its speed
    typedef struct packed {
        logic                below_db;
        logic                fwd;
        logic [PERIOD_W-1:0] duty;
    } lane_res_t;

    // Safety-check inputs of one command
    typedef struct packed {
        logic signed [TILT_W-1:0] tilt;
        logic [CUR_W-1:0]         current_left;
        logic [CUR_W-1:0]         current_right;
    } check_in_t;

    // One result item
    typedef struct packed {
        logic                stop_latched;
        logic                brake_right;
        logic                brake_left;
        logic                dir_right;
        logic                dir_left;
        logic [PERIOD_W-1:0] duty_right;
        logic [PERIOD_W-1:0] duty_left;
        logic [2:0]          status;
    } result_t;

endpackage

// ----- src/dual_hbridge_drive_with_fault_latch.sv -----
// ------------------------------------------------------------------------
// dual_hbridge_drive_with_fault_latch
// Two-channel H-bridge command processor with deadband and stop latch.
// ------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  s_*     | in        | s_tvalid / s_tready    | command item, op in s_tuser
//  m_*     | out       | m_tvalid / m_tready    | result item
//  cfg_*   | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
//  One item per cycle while s_tready is high; a result appears in the cycle
//  after its item is taken. Both lanes scale the speed with one 15x16
//  multiply each; the merge logic updates the drive state in the same cycle.
//  The output register holds a result while m_tready is low; s_tready stays
//  high as long as the output register is empty or is being read.
//  Reset clears the drive state and loads the register defaults.
// ------------------------------------------------------------------------
module dual_hbridge_drive_with_fault_latch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // motor[1:0], speed_a[17:2], speed_b[33:18], tilt[49:34],
    // current_left[61:50], current_right[73:62], zeros above
    input  logic [79:0] s_tdata,
    // op[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], duty_left[18:3], duty_right[34:19], dir_left[35],
    // dir_right[36], brake_left[37], brake_right[38], stop_latched[39]
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    hbd_pkg::cfg_t       cfg_reg;
    hbd_pkg::lane_res_t  lane_res [hbd_pkg::NUM_CH];
    hbd_pkg::result_t    res;
    hbd_pkg::result_t    res_reg;
    hbd_pkg::check_in_t  chk;
    logic                out_valid_reg;
    logic                accept;
    logic [1:0]          motor;
    logic signed [15:0]  speed_a;
    logic signed [15:0]  speed_b;
    logic signed [15:0]  lane1_speed;

    // Unpack the command item
    assign motor             = s_tdata[1:0];
    assign speed_a           = s_tdata[17:2];
    assign speed_b           = s_tdata[33:18];
    assign chk.tilt          = s_tdata[49:34];
    assign chk.current_left  = s_tdata[61:50];
    assign chk.current_right = s_tdata[73:62];

    assign s_tready    = ~out_valid_reg | m_tready;
    assign accept      = s_tvalid & s_tready;
    assign lane1_speed = (s_tuser == hbd_pkg::OP_SET_BOTH) ? speed_b : speed_a;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_period          <= hbd_pkg::PERIOD_RST;
            cfg_reg.deadband_left       <= hbd_pkg::DB_RST;
            cfg_reg.deadband_right      <= hbd_pkg::DB_RST;
            cfg_reg.current_limit_left  <= hbd_pkg::LIMIT_RST;
            cfg_reg.current_limit_right <= hbd_pkg::LIMIT_RST;
            cfg_reg.tilt_cutoff         <= hbd_pkg::CUTOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hbd_pkg::REG_PWM_PERIOD: cfg_reg.pwm_period          <= cfg_data;
                hbd_pkg::REG_DB_LEFT:    cfg_reg.deadband_left       <= cfg_data[13:0];
                hbd_pkg::REG_DB_RIGHT:   cfg_reg.deadband_right      <= cfg_data[13:0];
                hbd_pkg::REG_ILIM_LEFT:  cfg_reg.current_limit_left  <= cfg_data[10:0];
                hbd_pkg::REG_ILIM_RIGHT: cfg_reg.current_limit_right <= cfg_data[10:0];
                hbd_pkg::REG_TILT_CUT:   cfg_reg.tilt_cutoff         <= cfg_data[13:0];
                default:                 ;
            endcase
        end
    end

    // Channel lanes
    hbd_lane u_lane_left (
        .speed      (speed_a),
        .deadband   (cfg_reg.deadband_left),
        .pwm_period (cfg_reg.pwm_period),
        .res        (lane_res[0])
    );

    hbd_lane u_lane_right (
        .speed      (lane1_speed),
        .deadband   (cfg_reg.deadband_right),
        .pwm_period (cfg_reg.pwm_period),
        .res        (lane_res[1])
    );

    // Decode and merge
    hbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .op       (s_tuser),
        .motor    (motor),
        .chk      (chk),
        .cfg      (cfg_reg),
        .lane_res (lane_res),
        .res      (res)
    );

    // Output register: load on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

endmodule

// ----- src/hbd_lane.sv -----
// ------------------------------------------------------------------------
// hbd_lane
// One channel lane: clamp the speed, test the deadband, scale to a duty.
// ------------------------------------------------------------------------
module hbd_lane (
    input  logic signed [hbd_pkg::SPEED_W-1:0]  speed,
    input  logic        [hbd_pkg::DB_W-1:0]     deadband,
    input  logic        [hbd_pkg::PERIOD_W-1:0] pwm_period,
    output hbd_pkg::lane_res_t                  res
);

    logic signed [hbd_pkg::SPEED_W:0]   speed_sx;
    logic        [hbd_pkg::SPEED_W:0]   speed_abs;
    logic        [hbd_pkg::MAG_W-1:0]   mag;
    logic        [hbd_pkg::PROD_W-1:0]  prod;
    logic        [hbd_pkg::PERIOD_W:0]  duty_full;

    // Clamp the magnitude to full scale
    always_comb
    begin
        speed_sx  = {speed[hbd_pkg::SPEED_W-1], speed};
        speed_abs = speed[hbd_pkg::SPEED_W-1] ? (hbd_pkg::SPEED_W+1)'(-speed_sx)
                                              : (hbd_pkg::SPEED_W+1)'(speed_sx);
        if (speed_abs > {2'b00, hbd_pkg::SPEED_ONE})
        begin
            mag = hbd_pkg::SPEED_ONE;
        end
        else
        begin
            mag = speed_abs[hbd_pkg::MAG_W-1:0];
        end
    end

    // Scale by the period and saturate at it
    assign prod      = {{hbd_pkg::PERIOD_W{1'b0}}, mag} * {{hbd_pkg::MAG_W{1'b0}}, pwm_period};
    assign duty_full = prod[hbd_pkg::PROD_W-1:hbd_pkg::FRAC_W];

    always_comb
    begin
        res.below_db = (mag < {1'b0, deadband});
        res.fwd      = ~speed[hbd_pkg::SPEED_W-1];
        if (duty_full > {1'b0, pwm_period})
        begin
            res.duty = pwm_period;
        end
        else
        begin
            res.duty = duty_full[hbd_pkg::PERIOD_W-1:0];
        end
    end

endmodule

// ----- src/hbd_ctrl.sv -----
// ------------------------------------------------------------------------
// hbd_ctrl
// Command decode and merge: checks, stop latch and per-channel drive state.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module hbd_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [2:0]                          op,
    input  logic [1:0]                          motor,
    input  hbd_pkg::check_in_t                  chk,
    input  hbd_pkg::cfg_t                       cfg,
    input  hbd_pkg::lane_res_t                  lane_res [hbd_pkg::NUM_CH],
    output hbd_pkg::result_t                    res
);

    logic                          ready_reg,  ready_next;
    logic                          estop_reg,  estop_next;
    logic [hbd_pkg::PERIOD_W-1:0]  duty_reg   [hbd_pkg::NUM_CH];
    logic [hbd_pkg::PERIOD_W-1:0]  duty_next  [hbd_pkg::NUM_CH];
    logic                          dir_reg    [hbd_pkg::NUM_CH];
    logic                          dir_next   [hbd_pkg::NUM_CH];
    logic                          brake_reg  [hbd_pkg::NUM_CH];
    logic                          brake_next [hbd_pkg::NUM_CH];

    logic [hbd_pkg::NUM_CH-1:0]    drive_sel;
    logic [hbd_pkg::NUM_CH-1:0]    hold_sel;
    logic                          hold_brake;
    logic                          do_stop;
    logic                          do_init;
    logic [2:0]                    status;
    logic [hbd_pkg::TILT_W-1:0]    tilt_abs;
    logic                          tilt_over;
    logic                          left_over;
    logic                          right_over;
    logic                          duty_zero;
    logic                          init_taken;
    logic                          estop_taken;
    logic                          brakes_set;

    // Safety comparisons
    always_comb
    begin
        tilt_abs   = chk.tilt[hbd_pkg::TILT_W-1] ? hbd_pkg::TILT_W'(-chk.tilt)
                                                 : hbd_pkg::TILT_W'(chk.tilt);
        tilt_over  = (tilt_abs > {2'b00, cfg.tilt_cutoff});
        left_over  = (chk.current_left  > {1'b0, cfg.current_limit_left});
        right_over = (chk.current_right > {1'b0, cfg.current_limit_right});
    end

    // Decode the command into actions and a status
    always_comb
    begin
        drive_sel  = '0;
        hold_sel   = '0;
        hold_brake = 1'b0;
        do_stop    = 1'b0;
        do_init    = 1'b0;
        status     = hbd_pkg::ST_OK;
        case (op)
            hbd_pkg::OP_INIT:
            begin
                do_init = 1'b1;
            end
            hbd_pkg::OP_SET_SPEED:
            begin
                if (!ready_reg)
                    status = hbd_pkg::ST_NOT_INIT;
                else if (estop_reg)
                    status = hbd_pkg::ST_FAULT;
                else if (motor[1])
                    status = hbd_pkg::ST_INVALID;
                else
                    drive_sel = motor[0] ? 2'b10 : 2'b01;
            end
            hbd_pkg::OP_SET_BOTH:
            begin
                if (!ready_reg)
                    status = hbd_pkg::ST_NOT_INIT;
                else if (estop_reg)
                    status = hbd_pkg::ST_FAULT;
                else
                    drive_sel = 2'b11;
            end
            hbd_pkg::OP_BRAKE,
            hbd_pkg::OP_COAST:
            begin
                hold_brake = (op == hbd_pkg::OP_BRAKE);
                if (!ready_reg)
                    status = hbd_pkg::ST_NOT_INIT;
                else if (motor[1])
                    status = hbd_pkg::ST_INVALID;
                else
                    hold_sel = motor[0] ? 2'b10 : 2'b01;
            end
            hbd_pkg::OP_ESTOP:
            begin
                do_stop = 1'b1;
            end
            hbd_pkg::OP_CHECK:
            begin
                if (!ready_reg)
                begin
                    status = hbd_pkg::ST_NOT_INIT;
                end
                else if (tilt_over)
                begin
                    do_stop = 1'b1;
                    status  = hbd_pkg::ST_FAULT;
                end
                else if (left_over || right_over)
                begin
                    do_stop = 1'b1;
                    status  = hbd_pkg::ST_OVERCURRENT;
                end
            end
            default:
            begin
                status = hbd_pkg::ST_INVALID;
            end
        endcase
    end

    // Merge the lane results into the next channel state
    always_comb
    begin
        ready_next = ready_reg | do_init;
        estop_next = (estop_reg & ~do_init) | do_stop;
        for (int i = 0; i < hbd_pkg::NUM_CH; i++)
        begin
            duty_next[i]  = duty_reg[i];
            dir_next[i]   = dir_reg[i];
            brake_next[i] = brake_reg[i];
            if (do_init)
            begin
                duty_next[i]  = '0;
                brake_next[i] = 1'b0;
            end
            if (do_stop)
            begin
                duty_next[i]  = '0;
                brake_next[i] = 1'b1;
            end
            if (hold_sel[i])
            begin
                duty_next[i]  = '0;
                brake_next[i] = hold_brake;
            end
            if (drive_sel[i])
            begin
                brake_next[i] = 1'b0;
                if (lane_res[i].below_db)
                begin
                    duty_next[i] = '0;
                end
                else
                begin
                    dir_next[i]  = lane_res[i].fwd;
                    duty_next[i] = lane_res[i].duty;
                end
            end
        end
    end

    // Hold the drive state, advance it on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            estop_reg <= 1'b0;
            for (int i = 0; i < hbd_pkg::NUM_CH; i++)
            begin
                duty_reg[i]  <= '0;
                dir_reg[i]   <= 1'b0;
                brake_reg[i] <= 1'b0;
            end
        end
        else if (accept)
        begin
            ready_reg <= ready_next;
            estop_reg <= estop_next;
            for (int i = 0; i < hbd_pkg::NUM_CH; i++)
            begin
                duty_reg[i]  <= duty_next[i];
                dir_reg[i]   <= dir_next[i];
                brake_reg[i] <= brake_next[i];
            end
        end
    end

    // Result shows the state after the command
    always_comb
    begin
        res.status       = status;
        res.duty_left    = duty_next[0];
        res.duty_right   = duty_next[1];
        res.dir_left     = dir_next[0];
        res.dir_right    = dir_next[1];
        res.brake_left   = brake_next[0];
        res.brake_right  = brake_next[1];
        res.stop_latched = estop_next;
    end

    // Terms for the checks below
    assign duty_zero   = (duty_reg[0] == '0) && (duty_reg[1] == '0);
    assign init_taken  = accept && (op == hbd_pkg::OP_INIT);
    assign estop_taken = accept && (op == hbd_pkg::OP_ESTOP);
    assign brakes_set  = brake_reg[0] && brake_reg[1];

    // A latched stop or an uninitialized drive never leaves a duty running
    `HBD_ASSERT_ALWAYS(a_stop_zero_duty, (!estop_reg || duty_zero), "duty set while stop latched")
    `HBD_ASSERT_ALWAYS(a_idle_zero_duty, (ready_reg || duty_zero), "duty nonzero before init")
    `HBD_ASSERT(a_init_clears, (init_taken |=> ready_reg && !estop_reg), "init kept the latch")
    `HBD_ASSERT(a_estop_sets, (estop_taken |=> estop_reg && brakes_set), "estop did not latch")

endmodule

// ----- tb/testbench.sv -----
// ------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual H-bridge drive. Commands go in on the
// s_* stream and results come back on m_*. A scoreboard object predicts
// every result from its own copy of the drive state and registers, then
// compares each returned item field by field. Directed commands cover the
// corner cases; random commands run under several register settings.
// ------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Op code outside the defined command set
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 400000;

    // One command item
    typedef struct {
        logic [2:0]         op;
        logic [1:0]         motor;
        logic signed [15:0] speed_a;
        logic signed [15:0] speed_b;
        logic signed [15:0] tilt;
        logic [11:0]        current_left;
        logic [11:0]        current_right;
    } drive_cmd_t;

    // Drive state mirror and queue of predicted results
    class drive_scoreboard;
        hbd_pkg::cfg_t    cfg;
        logic             ready;
        logic             latched;
        logic [15:0]      duty_now [2];
        logic             dir_now [2];
        logic             brake_now [2];
        hbd_pkg::result_t pending_q [$];
        int               errors;
        int               checked;
        int               latch_count;

        function new();
            cfg.pwm_period          = hbd_pkg::PERIOD_RST;
            cfg.deadband_left       = hbd_pkg::DB_RST;
            cfg.deadband_right      = hbd_pkg::DB_RST;
            cfg.current_limit_left  = hbd_pkg::LIMIT_RST;
            cfg.current_limit_right = hbd_pkg::LIMIT_RST;
            cfg.tilt_cutoff         = hbd_pkg::CUTOFF_RST;
            ready   = 1'b0;
            latched = 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                duty_now[i]  = '0;
                dir_now[i]   = 1'b0;
                brake_now[i] = 1'b0;
            end
            errors      = 0;
            checked     = 0;
            latch_count = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                hbd_pkg::REG_PWM_PERIOD: cfg.pwm_period          = val;
                hbd_pkg::REG_DB_LEFT:    cfg.deadband_left       = val[13:0];
                hbd_pkg::REG_DB_RIGHT:   cfg.deadband_right      = val[13:0];
                hbd_pkg::REG_ILIM_LEFT:  cfg.current_limit_left  = val[10:0];
                hbd_pkg::REG_ILIM_RIGHT: cfg.current_limit_right = val[10:0];
                hbd_pkg::REG_TILT_CUT:   cfg.tilt_cutoff         = val[13:0];
                default: ;
            endcase
        endfunction

        // Clamp, apply deadband, scale to the PWM period
        function void drive_lane(int ch, logic signed [15:0] spd);
            int     s;
            int     mag;
            int     db;
            longint scaled;
            s = int'(spd);
            if (s > 16384)
                s = 16384;
            if (s < -16384)
                s = -16384;
            mag = (s >= 0) ? s : -s;
            db  = (ch == 0) ? int'(cfg.deadband_left) : int'(cfg.deadband_right);
            brake_now[ch] = 1'b0;
            if (mag < db)
            begin
                duty_now[ch] = '0;
                return;
            end
            dir_now[ch] = (s >= 0);
            scaled = (longint'(mag) * longint'(cfg.pwm_period)) >>> 14;
            if (scaled > longint'(cfg.pwm_period))
                scaled = longint'(cfg.pwm_period);
            duty_now[ch] = scaled[15:0];
        endfunction

        function void latch_stop();
            duty_now[0]  = '0;
            duty_now[1]  = '0;
            brake_now[0] = 1'b1;
            brake_now[1] = 1'b1;
            latched      = 1'b1;
        endfunction

        // Predict the result of one accepted command
        function void note_command(drive_cmd_t c);
            logic [2:0]       st;
            int               atilt;
            hbd_pkg::result_t r;
            st = hbd_pkg::ST_OK;
            case (c.op)
                hbd_pkg::OP_INIT:
                begin
                    latched      = 1'b0;
                    duty_now[0]  = '0;
                    duty_now[1]  = '0;
                    brake_now[0] = 1'b0;
                    brake_now[1] = 1'b0;
                    ready        = 1'b1;
                end
                hbd_pkg::OP_SET_SPEED:
                begin
                    if (!ready)
                        st = hbd_pkg::ST_NOT_INIT;
                    else if (latched)
                        st = hbd_pkg::ST_FAULT;
                    else if (c.motor > 2'd1)
                        st = hbd_pkg::ST_INVALID;
                    else
                        drive_lane(int'(c.motor), c.speed_a);
                end
                hbd_pkg::OP_SET_BOTH:
                begin
                    if (!ready)
                        st = hbd_pkg::ST_NOT_INIT;
                    else if (latched)
                        st = hbd_pkg::ST_FAULT;
                    else
                    begin
                        drive_lane(0, c.speed_a);
                        drive_lane(1, c.speed_b);
                    end
                end
                hbd_pkg::OP_BRAKE, hbd_pkg::OP_COAST:
                begin
                    if (!ready)
                        st = hbd_pkg::ST_NOT_INIT;
                    else if (c.motor > 2'd1)
                        st = hbd_pkg::ST_INVALID;
                    else
                    begin
                        duty_now[c.motor[0]]  = '0;
                        brake_now[c.motor[0]] = (c.op == hbd_pkg::OP_BRAKE);
                    end
                end
                hbd_pkg::OP_ESTOP:
                    latch_stop();
                hbd_pkg::OP_CHECK:
                begin
                    atilt = int'(c.tilt);
                    if (atilt < 0)
                        atilt = -atilt;
                    if (!ready)
                        st = hbd_pkg::ST_NOT_INIT;
                    else if (atilt > int'(cfg.tilt_cutoff))
                    begin
                        latch_stop();
                        st = hbd_pkg::ST_FAULT;
                    end
                    else if (c.current_left > {1'b0, cfg.current_limit_left})
                    begin
                        latch_stop();
                        st = hbd_pkg::ST_OVERCURRENT;
                    end
                    else if (c.current_right > {1'b0, cfg.current_limit_right})
                    begin
                        latch_stop();
                        st = hbd_pkg::ST_OVERCURRENT;
                    end
                end
                default:
                    st = hbd_pkg::ST_INVALID;
            endcase
            r.status       = st;
            r.duty_left    = duty_now[0];
            r.duty_right   = duty_now[1];
            r.dir_left     = dir_now[0];
            r.dir_right    = dir_now[1];
            r.brake_left   = brake_now[0];
            r.brake_right  = brake_now[1];
            r.stop_latched = latched;
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one returned item with the oldest prediction
        function void check_result(hbd_pkg::result_t got);
            hbd_pkg::result_t want;
            if (pending_q.size() == 0)
            begin
                $error("result item with no command pending: %h", got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("duty_left", want.duty_left, got.duty_left);
            compare_field("duty_right", want.duty_right, got.duty_right);
            compare_field("dir_left", want.dir_left, got.dir_left);
            compare_field("dir_right", want.dir_right, got.dir_right);
            compare_field("brake_left", want.brake_left, got.brake_left);
            compare_field("brake_right", want.brake_right, got.brake_right);
            compare_field("stop_latched", want.stop_latched, got.stop_latched);
            if (want.stop_latched)
                latch_count++;
            checked++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    drive_scoreboard sb;
    int sent_count;
    int recv_count;
    int settings_count;
    int cycle_count;

    dual_hbridge_drive_with_fault_latch u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Offer one command after a random gap and wait for it to be taken
    task automatic send_cmd(input drive_cmd_t c);
        int gap;
        gap = ((sent_count / 40) % 4 == 3) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {6'd0, c.current_right, c.current_left, c.tilt,
                     c.speed_b, c.speed_a, c.motor};
        s_tuser  <= c.op;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(c);
        sent_count++;
    endtask

    task automatic issue(input logic [2:0] op, input logic [1:0] motor,
                         input int sa, input int sb_spd, input int tilt,
                         input int cl, input int cr);
        drive_cmd_t c;
        c.op            = op;
        c.motor         = motor;
        c.speed_a       = sa[15:0];
        c.speed_b       = sb_spd[15:0];
        c.tilt          = tilt[15:0];
        c.current_left  = cl[11:0];
        c.current_right = cr[11:0];
        send_cmd(c);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        cfg_we    <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, val[15:0]);
    endtask

    // Load one full register set; settings 1-3 are extremes, 4 the defaults
    task automatic apply_setting(input int phase);
        int period, db_l, db_r, lim_l, lim_r, cut;
        case (phase)
            1: begin period = 1; db_l = 0; db_r = 0; lim_l = 1; lim_r = 1; cut = 1; end
            2: begin
                period = 65535; db_l = 8192; db_r = 8192;
                lim_l = 2000; lim_r = 2000; cut = 9000;
            end
            3: begin
                period = 0; db_l = 16383; db_r = 16383;
                lim_l = 2047; lim_r = 2047; cut = 16383;
            end
            4: begin
                period = 1000; db_l = 819; db_r = 819;
                lim_l = 2000; lim_r = 2000; cut = 4500;
            end
            default:
            begin
                period = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50)
                                                     : $urandom_range(1, 65535);
                db_l  = $urandom_range(0, 8192);
                db_r  = $urandom_range(0, 8192);
                lim_l = $urandom_range(1, 2000);
                lim_r = $urandom_range(1, 2000);
                cut   = $urandom_range(1, 9000);
            end
        endcase
        write_reg(hbd_pkg::REG_PWM_PERIOD, period);
        write_reg(hbd_pkg::REG_DB_LEFT, db_l);
        write_reg(hbd_pkg::REG_DB_RIGHT, db_r);
        write_reg(hbd_pkg::REG_ILIM_LEFT, lim_l);
        write_reg(hbd_pkg::REG_ILIM_RIGHT, lim_r);
        write_reg(hbd_pkg::REG_TILT_CUT, cut);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Speeds near the deadband edge, at the clamp points, or anywhere
    function automatic logic signed [15:0] pick_speed(int db);
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 65535) - 32768;
            1: v = db + $urandom_range(0, 6) - 3;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 16384;
                    3: v = -16384;
                    4: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom_range(0, 32768) - 16384;
        endcase
        if (($urandom_range(0, 1) == 1) && (v > 0) && (v < 32768))
            v = -v;
        return v[15:0];
    endfunction

    function automatic drive_cmd_t make_random_cmd();
        drive_cmd_t c;
        int sel;
        int cut;
        sel = $urandom_range(0, 99);
        if (sel < 8)       c.op = hbd_pkg::OP_INIT;
        else if (sel < 33) c.op = hbd_pkg::OP_SET_SPEED;
        else if (sel < 53) c.op = hbd_pkg::OP_SET_BOTH;
        else if (sel < 61) c.op = hbd_pkg::OP_BRAKE;
        else if (sel < 69) c.op = hbd_pkg::OP_COAST;
        else if (sel < 72) c.op = hbd_pkg::OP_ESTOP;
        else if (sel < 96) c.op = hbd_pkg::OP_CHECK;
        else               c.op = OP_UNUSED;
        c.motor   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                : 2'($urandom_range(0, 1));
        c.speed_a = pick_speed(c.motor == 2'd1 ? int'(sb.cfg.deadband_right)
                                               : int'(sb.cfg.deadband_left));
        c.speed_b = pick_speed(int'(sb.cfg.deadband_right));
        cut = int'(sb.cfg.tilt_cutoff);
        if ($urandom_range(0, 9) < 7)
            c.tilt = 16'($urandom_range(0, 2 * cut) - cut);
        else
            c.tilt = 16'($urandom_range(0, 36000) - 18000);
        c.current_left  = ($urandom_range(0, 9) < 8)
                        ? 12'($urandom_range(0, sb.cfg.current_limit_left))
                        : 12'($urandom_range(0, 4095));
        c.current_right = ($urandom_range(0, 9) < 8)
                        ? 12'($urandom_range(0, sb.cfg.current_limit_right))
                        : 12'($urandom_range(0, 4095));
        return c;
    endfunction

    // Result side: random stalls, bursts without stalls, one long hold
    initial
    begin : result_sink
        int stall;
        m_tready   = 1'b0;
        recv_count = 0;
        forever
        begin
            if (recv_count == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((recv_count / 64) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(hbd_pkg::result_t'(m_tdata));
            recv_count++;
        end
    end

    // Watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : main_seq
        sb             = new();
        sent_count     = 0;
        settings_count = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values
        issue(hbd_pkg::OP_SET_SPEED, 2'd0, 8000, 0, 0, 0, 0);
        issue(hbd_pkg::OP_CHECK, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_COAST, 2'd1, 0, 0, 0, 0, 0);
        issue(OP_UNUSED, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_ESTOP, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_INIT, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_SET_SPEED, 2'd0, 32767, 0, 0, 0, 0);
        issue(hbd_pkg::OP_SET_SPEED, 2'd1, -32768, 0, 0, 0, 0);
        issue(hbd_pkg::OP_SET_SPEED, 2'd2, 5000, 0, 0, 0, 0);
        issue(hbd_pkg::OP_BRAKE, 2'd3, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_SET_SPEED, 2'd0, 818, 0, 0, 0, 0);
        issue(hbd_pkg::OP_SET_SPEED, 2'd1, 819, 0, 0, 0, 0);
        issue(hbd_pkg::OP_SET_BOTH, 2'd0, -16384, 16384, 0, 0, 0);
        issue(hbd_pkg::OP_BRAKE, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_COAST, 2'd1, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_CHECK, 2'd0, 0, 0, 4500, 2000, 2000);
        issue(hbd_pkg::OP_CHECK, 2'd0, 0, 0, -4501, 0, 0);
        issue(hbd_pkg::OP_SET_SPEED, 2'd0, 9000, 0, 0, 0, 0);
        issue(hbd_pkg::OP_SET_BOTH, 2'd0, 9000, -9000, 0, 0, 0);
        issue(hbd_pkg::OP_BRAKE, 2'd1, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_INIT, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_CHECK, 2'd0, 0, 0, 0, 2001, 0);
        issue(hbd_pkg::OP_INIT, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_CHECK, 2'd0, 0, 0, 0, 0, 2001);
        issue(hbd_pkg::OP_INIT, 2'd0, 0, 0, 0, 0, 0);
        issue(hbd_pkg::OP_CHECK, 2'd0, 0, 0, 18000, 4095, 4095);
        issue(hbd_pkg::OP_INIT, 2'd0, 0, 0, 0, 0, 0);

        // Random commands under each register setting
        for (int phase = 1; phase <= RANDOM_PHASES; phase++)
        begin
            drain();
            apply_setting(phase);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_cmd(make_random_cmd());
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Checked %0d results from %0d commands under %0d register settings.",
                 sb.checked, sent_count, settings_count + 1);
        $display("Stop latch was set in %0d results; %0d mismatches.",
                 sb.latch_count, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
